// ----- rtl/mi3_pkg.sv -----
// shared widths, pipeline depths and flag bundle for the 3x3 matrix inverse core
// no dependencies
`default_nettype none

package mi3_pkg;

   localparam int ELEM_W    = 16;   // Q8.8 input element
   localparam int PROD_W    = 32;   // product of two elements
   localparam int COF_W     = 33;   // cofactor, Q16.16
   localparam int DPROD_W   = 49;   // element times cofactor
   localparam int DET_W     = 51;   // determinant sum, Q24.24 with headroom
   localparam int MAG_W     = 32;   // cofactor magnitude
   localparam int DEN_W     = 49;   // determinant magnitude
   localparam int REM_W     = 50;   // partial remainder plus shifted-in bit
   localparam int Q_W       = 33;   // quotient bits kept by the divider
   localparam int OUT_W     = 32;   // Q8.24 result element
   localparam int LANES     = 9;
   localparam int DIV_STEPS = 33;   // one quotient bit per stage
   localparam int FRONT     = 5;    // products, cofactors, det products, det, prep
   localparam int NSTAGE    = FRONT + DIV_STEPS + 1;

   localparam logic [Q_W-1:0] POS_MAX = Q_W'(33'h0_7FFF_FFFF);
   localparam logic [Q_W-1:0] NEG_MAX = Q_W'(33'h0_8000_0000);

   // per-request side information that rides along with the divider
   typedef struct packed {
      logic [LANES-1:0] neg;
      logic [LANES-1:0] ovf;
      logic             singular;
   } mi3_flag_type;

endpackage

`default_nettype wire

// ----- rtl/matrix3x3_inverse_core.sv -----
// 3x3 matrix inverse by the adjugate method, Q8.8 in, Q8.24 out
// depends on mi3_pkg and mi3_div
`default_nettype none

// One request carries a whole 3x3 matrix and yields one response with the
// nine inverse elements, a singular flag and a saturated flag. The core is a
// 39-stage pipeline: five stages form products, cofactors and the
// determinant, 33 stages run nine bit-per-stage dividers in parallel, and
// one output register holds the response. A new request is taken every
// cycle unless a response stall backs up to the input. Each stage advances
// on its own, so bubbles are squeezed out when the response side stalls.

module matrix3x3_inverse_core
   import mi3_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_ready,
   input  wire logic signed [ELEM_W-1:0] req_in_00,
   input  wire logic signed [ELEM_W-1:0] req_in_01,
   input  wire logic signed [ELEM_W-1:0] req_in_02,
   input  wire logic signed [ELEM_W-1:0] req_in_10,
   input  wire logic signed [ELEM_W-1:0] req_in_11,
   input  wire logic signed [ELEM_W-1:0] req_in_12,
   input  wire logic signed [ELEM_W-1:0] req_in_20,
   input  wire logic signed [ELEM_W-1:0] req_in_21,
   input  wire logic signed [ELEM_W-1:0] req_in_22,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   output      logic signed [OUT_W-1:0]  rsp_out_00,
   output      logic signed [OUT_W-1:0]  rsp_out_01,
   output      logic signed [OUT_W-1:0]  rsp_out_02,
   output      logic signed [OUT_W-1:0]  rsp_out_10,
   output      logic signed [OUT_W-1:0]  rsp_out_11,
   output      logic signed [OUT_W-1:0]  rsp_out_12,
   output      logic signed [OUT_W-1:0]  rsp_out_20,
   output      logic signed [OUT_W-1:0]  rsp_out_21,
   output      logic signed [OUT_W-1:0]  rsp_out_22,
   output      logic                     rsp_singular,
   output      logic                     rsp_saturated
);

   localparam int DIV0 = FRONT;
   localparam int LAST = NSTAGE - 1;

   logic [NSTAGE-1:0] valid_ff;
   logic [NSTAGE-1:0] valid_in;
   logic [NSTAGE-1:0] en;

   logic signed [ELEM_W-1:0] m [LANES];

   logic signed [PROD_W-1:0]  pa_ff [LANES];
   logic signed [PROD_W-1:0]  pb_ff [LANES];
   logic signed [ELEM_W-1:0]  row0_f1_ff [3];
   logic signed [COF_W-1:0]   cof_f2_ff [LANES];
   logic signed [ELEM_W-1:0]  row0_f2_ff [3];
   logic signed [DPROD_W-1:0] dp_ff [3];
   logic signed [COF_W-1:0]   cof_f3_ff [LANES];
   logic signed [DET_W-1:0]   det_ff;
   logic signed [COF_W-1:0]   cof_f4_ff [LANES];

   logic [REM_W-1:0] rem_in  [LANES];
   logic [REM_W-1:0] rem_ff  [LANES];
   logic [LANES-1:0] bit_in, bit_ff;
   logic [DEN_W-1:0] den_in, den_ff;
   mi3_flag_type     flag_in, flag_ff;

   logic [Q_W-1:0]   quo [LANES];
   mi3_flag_type     dflag;

   logic [OUT_W-1:0] out_in [LANES];
   logic [OUT_W-1:0] out_ff [LANES];
   logic             sing_in, sing_ff, sat_in, sat_ff;

   assign m[0] = req_in_00;
   assign m[1] = req_in_01;
   assign m[2] = req_in_02;
   assign m[3] = req_in_10;
   assign m[4] = req_in_11;
   assign m[5] = req_in_12;
   assign m[6] = req_in_20;
   assign m[7] = req_in_21;
   assign m[8] = req_in_22;

   // per-stage advance: a stage loads when it is empty or its successor moves
   always_comb begin
      en[LAST] = !valid_ff[LAST] || rsp_ready;
      for (int i = LAST - 1; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
      valid_in = {valid_ff[NSTAGE-2:0], req_valid};
   end

   assign req_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NSTAGE; i++) begin
            if (en[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   // stage 0: the two minor products of every cofactor
   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               pa_ff[r*3+c] <= m[((r+1)%3)*3 + (c+1)%3] * m[((r+2)%3)*3 + (c+2)%3];
               pb_ff[r*3+c] <= m[((r+1)%3)*3 + (c+2)%3] * m[((r+2)%3)*3 + (c+1)%3];
            end
         end
         for (int c = 0; c < 3; c++) begin
            row0_f1_ff[c] <= m[c];
         end
      end
   end

   // stage 1: cofactors
   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int i = 0; i < LANES; i++) begin
            cof_f2_ff[i] <= pa_ff[i] - pb_ff[i];
         end
         row0_f2_ff <= row0_f1_ff;
      end
   end

   // stage 2: first-row terms of the determinant
   always_ff @(posedge clock) begin
      if (en[2]) begin
         for (int c = 0; c < 3; c++) begin
            dp_ff[c] <= row0_f2_ff[c] * cof_f2_ff[c];
         end
         cof_f3_ff <= cof_f2_ff;
      end
   end

   // stage 3: determinant
   always_ff @(posedge clock) begin
      if (en[3]) begin
         det_ff    <= dp_ff[0] + dp_ff[1] + dp_ff[2];
         cof_f4_ff <= cof_f3_ff;
      end
   end

   // stage 4: magnitudes, signs, overflow precheck, divider seed (transposed)
   always_comb begin
      logic signed [COF_W-1:0] x;
      logic [COF_W-1:0]        xmag;
      logic [DET_W-1:0]        dmag;
      dmag   = det_ff[DET_W-1] ? DET_W'(-det_ff) : DET_W'(det_ff);
      den_in = dmag[DEN_W-1:0];
      flag_in.singular = (det_ff == '0);
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            x    = cof_f4_ff[c*3+r];
            xmag = x[COF_W-1] ? COF_W'(-x) : COF_W'(x);
            flag_in.neg[r*3+c] = x[COF_W-1] ^ det_ff[DET_W-1];
            flag_in.ovf[r*3+c] = {{(REM_W-MAG_W){1'b0}}, xmag[MAG_W-1:0]} >= {den_in, 1'b0};
            rem_in[r*3+c] = {{(REM_W-MAG_W+1){1'b0}}, xmag[MAG_W-1:1]};
            bit_in[r*3+c] = xmag[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         rem_ff  <= rem_in;
         bit_ff  <= bit_in;
         den_ff  <= den_in;
         flag_ff <= flag_in;
      end
   end

   mi3_div u_div (
      .clock    (clock),
      .step_en  (en[DIV0 +: DIV_STEPS]),
      .den_in   (den_ff),
      .rem_in   (rem_ff),
      .bit_in   (bit_ff),
      .flag_in  (flag_ff),
      .quo_out  (quo),
      .flag_out (dflag)
   );

   // output stage: sign, saturation, singular override
   always_comb begin
      logic s;
      sat_in  = 1'b0;
      sing_in = dflag.singular;
      for (int l = 0; l < LANES; l++) begin
         if (dflag.neg[l]) begin
            s         = dflag.ovf[l] || (quo[l] > NEG_MAX);
            out_in[l] = s ? NEG_MAX[OUT_W-1:0] : OUT_W'(-quo[l]);
         end else begin
            s         = dflag.ovf[l] || (quo[l] > POS_MAX);
            out_in[l] = s ? POS_MAX[OUT_W-1:0] : quo[l][OUT_W-1:0];
         end
         if (dflag.singular) begin
            out_in[l] = '0;
         end else begin
            sat_in = sat_in | s;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[LAST]) begin
         out_ff  <= out_in;
         sing_ff <= sing_in;
         sat_ff  <= sat_in;
      end
   end

   assign rsp_valid     = valid_ff[LAST];
   assign rsp_out_00    = out_ff[0];
   assign rsp_out_01    = out_ff[1];
   assign rsp_out_02    = out_ff[2];
   assign rsp_out_10    = out_ff[3];
   assign rsp_out_11    = out_ff[4];
   assign rsp_out_12    = out_ff[5];
   assign rsp_out_20    = out_ff[6];
   assign rsp_out_21    = out_ff[7];
   assign rsp_out_22    = out_ff[8];
   assign rsp_singular  = sing_ff;
   assign rsp_saturated = sat_ff;

   // a singular response carries zeros and no saturation
   a_singular_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> !rsp_saturated && rsp_out_00 == '0 && rsp_out_22 == '0)
      else $error("singular response not cleared");

   // an empty output register never blocks the input
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   // a consumer that is ready never blocks the input
   a_flow_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while output drains");

endmodule

`default_nettype wire

// ----- rtl/mi3_div.sv -----
// nine restoring dividers sharing one denominator, one quotient bit per stage
// depends on mi3_pkg
`default_nettype none

module mi3_div
   import mi3_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic [DIV_STEPS-1:0] step_en,
   input  wire logic [DEN_W-1:0]     den_in,
   input  wire logic [REM_W-1:0]     rem_in [LANES],
   input  wire logic [LANES-1:0]     bit_in,
   input  wire mi3_flag_type         flag_in,
   output      logic [Q_W-1:0]       quo_out [LANES],
   output      mi3_flag_type         flag_out
);

   logic [REM_W-1:0] rem_ff  [DIV_STEPS][LANES];
   logic [Q_W-1:0]   quo_ff  [DIV_STEPS][LANES];
   logic [DEN_W-1:0] den_ff  [DIV_STEPS];
   mi3_flag_type     flag_ff [DIV_STEPS];

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [REM_W-1:0] rem_prev [LANES];
      logic [Q_W-1:0]   quo_prev [LANES];
      logic [LANES-1:0] bit_prev;
      logic [DEN_W-1:0] den_prev;
      mi3_flag_type     flag_prev;
      logic [REM_W-1:0] rem_next [LANES];
      logic [Q_W-1:0]   quo_next [LANES];

      // stage inputs: the first step shifts in the last numerator bit, later ones zero
      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            rem_prev[l] = (k == 0) ? rem_in[l] : rem_ff[(k == 0) ? 0 : k-1][l];
            quo_prev[l] = (k == 0) ? '0 : quo_ff[(k == 0) ? 0 : k-1][l];
         end
         bit_prev  = (k == 0) ? bit_in : '0;
         den_prev  = (k == 0) ? den_in : den_ff[(k == 0) ? 0 : k-1];
         flag_prev = (k == 0) ? flag_in : flag_ff[(k == 0) ? 0 : k-1];
      end

      // one trial subtract per lane
      always_comb begin
         logic [REM_W-1:0] trial;
         logic             ge;
         for (int l = 0; l < LANES; l++) begin
            trial       = {rem_prev[l][REM_W-2:0], bit_prev[l]};
            ge          = trial >= {1'b0, den_prev};
            rem_next[l] = ge ? trial - {1'b0, den_prev} : trial;
            quo_next[l] = {quo_prev[l][Q_W-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (step_en[k]) begin
            rem_ff[k]  <= rem_next;
            quo_ff[k]  <= quo_next;
            den_ff[k]  <= den_prev;
            flag_ff[k] <= flag_prev;
         end
      end
   end

   assign quo_out  = quo_ff[DIV_STEPS-1];
   assign flag_out = flag_ff[DIV_STEPS-1];

endmodule

`default_nettype wire

// ----- bench/tb_matrix3x3_inverse_core.sv -----
// testbench for matrix3x3_inverse_core: random and directed 3x3 matrices, inverse predicted
// in the bench with exact integer arithmetic and compared per field
// depends on mi3_pkg and the core rtl
`default_nettype none

module tb_matrix3x3_inverse_core
   import mi3_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_RANDOM    = 900;
   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN       = 200;

   typedef logic signed [ELEM_W-1:0] elem_type;

   typedef struct {
      elem_type e [9];
   } matrix_type;

   typedef struct {
      logic signed [OUT_W-1:0] inv [9];
      logic                    singular;
      logic                    saturated;
   } inverse_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   elem_type req_in [9];
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [OUT_W-1:0] rsp_out [9];
   logic rsp_singular, rsp_saturated;

   matrix_type  pending_matrices [$];
   inverse_type expected_inverses [$];
   int       n_fail = 0;
   int       n_done = 0;
   int       n_singular = 0;
   int       n_sat = 0;
   int       idle_cycles = 0;
   bit       stim_done = 1'b0;
   bit       req_taken = 1'b0;

   initial begin
      for (int i = 0; i < 9; i++) req_in[i] = '0;
   end

   matrix3x3_inverse_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_in_00(req_in[0]), .req_in_01(req_in[1]), .req_in_02(req_in[2]),
      .req_in_10(req_in[3]), .req_in_11(req_in[4]), .req_in_12(req_in[5]),
      .req_in_20(req_in[6]), .req_in_21(req_in[7]), .req_in_22(req_in[8]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_00(rsp_out[0]), .rsp_out_01(rsp_out[1]), .rsp_out_02(rsp_out[2]),
      .rsp_out_10(rsp_out[3]), .rsp_out_11(rsp_out[4]), .rsp_out_12(rsp_out[5]),
      .rsp_out_20(rsp_out[6]), .rsp_out_21(rsp_out[7]), .rsp_out_22(rsp_out[8]),
      .rsp_singular(rsp_singular), .rsp_saturated(rsp_saturated)
   );

   // clock
   initial begin
      forever #6 clock = ~clock;
   end

   // inverse by adjugate, quotient of magnitudes, then sign and clip
   function automatic inverse_type invert_matrix(matrix_type m);
      longint   a [3][3];
      longint   cof [3][3];
      longint   det, cv;
      logic [63:0] num, den, q;
      bit       neg;
      inverse_type res;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++) a[r][c] = longint'(m.e[r*3+c]);
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            cof[r][c] = a[(r+1)%3][(c+1)%3] * a[(r+2)%3][(c+2)%3]
                      - a[(r+1)%3][(c+2)%3] * a[(r+2)%3][(c+1)%3];
      det = a[0][0]*cof[0][0] + a[0][1]*cof[0][1] + a[0][2]*cof[0][2];
      res.singular = (det == 0);
      res.saturated = 1'b0;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++) begin
            res.inv[r*3+c] = '0;
            if (det != 0) begin
               cv  = cof[c][r];
               num = (cv < 0 ? -cv : cv) << 32;
               den = det < 0 ? -det : det;
               q   = num / den;
               neg = (cv < 0) != (det < 0);
               if (neg) begin
                  if (q > 64'h8000_0000) begin
                     res.saturated = 1'b1;
                     q = 64'h8000_0000;
                  end
                  res.inv[r*3+c] = OUT_W'(-q);
               end else begin
                  if (q > 64'h7FFF_FFFF) begin
                     res.saturated = 1'b1;
                     q = 64'h7FFF_FFFF;
                  end
                  res.inv[r*3+c] = OUT_W'(q);
               end
            end
         end
      return res;
   endfunction

   function automatic elem_type random_elem(int mode);
      case (mode)
         0: return elem_type'($urandom);
         1: return elem_type'($urandom_range(0, 1023)) - 16'sd512;
         2: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
         default: return elem_type'($urandom_range(0, 6)) - 16'sd3;
      endcase
   endfunction

   task automatic add_matrix(input elem_type v [9]);
      matrix_type m;
      for (int i = 0; i < 9; i++) m.e[i] = v[i];
      pending_matrices.push_back(m);
   endtask

   // directed then random stimulus
   initial begin
      elem_type v [9];
      int mode;
      // identity, scaled identity, extremes
      v = '{16'sh0100, 0, 0, 0, 16'sh0100, 0, 0, 0, 16'sh0100};
      add_matrix(v);
      v = '{16'sh7FFF, 0, 0, 0, 16'sh7FFF, 0, 0, 0, 16'sh7FFF};
      add_matrix(v);
      v = '{16'sh8000, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh8000};
      add_matrix(v);
      // tiny determinant: saturates both ways
      v = '{16'sd1, 0, 0, 0, 16'sd1, 0, 0, 0, 16'sd1};
      add_matrix(v);
      v = '{-16'sd1, 0, 0, 0, 16'sd1, 0, 0, 0, 16'sd1};
      add_matrix(v);
      v = '{16'sd1, 16'sd1, 0, 0, 16'sd1, 0, 0, 0, 16'sd1};
      add_matrix(v);
      // all zero and repeated rows are singular
      v = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
      add_matrix(v);
      v = '{16'sd5, -16'sd7, 16'sd9, 16'sd5, -16'sd7, 16'sd9, 16'sd1, 16'sd2, 16'sd3};
      add_matrix(v);
      for (int i = 0; i < 9; i++) v[i] = 16'sh8000;
      add_matrix(v);
      for (int i = 0; i < 9; i++) v[i] = 16'sh7FFF;
      add_matrix(v);
      for (int i = 0; i < 9; i++) v[i] = -16'sd1;
      add_matrix(v);
      // permutation with extreme entries, then a diagonal with mixed signs
      v = '{0, 16'sh8000, 0, 16'sh7FFF, 0, 0, 0, 0, 16'sh8000};
      add_matrix(v);
      v = '{16'sh0080, 0, 0, 0, -16'sh0080, 0, 0, 0, 16'sh0100};
      add_matrix(v);
      for (int n = 0; n < N_RANDOM; n++) begin
         mode = $urandom_range(0, 3);
         for (int i = 0; i < 9; i++) v[i] = random_elem(mode);
         // make some matrices singular by copying a row or column
         if ($urandom_range(0, 9) == 0) begin
            for (int c = 0; c < 3; c++) v[6+c] = v[c];
         end else if ($urandom_range(0, 19) == 0) begin
            for (int r = 0; r < 3; r++) v[r*3+2] = v[r*3];
         end
         add_matrix(v);
      end
   end

   // reset and end of run
   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      wait (pending_matrices.size() == 0 && stim_done);
      wait (expected_inverses.size() == 0);
      repeat (DRAIN) @(posedge clock);
      $display("checked %0d inverses: %0d singular, %0d saturated", n_done, n_singular, n_sat);
      if (n_fail == 0 && expected_inverses.size() == 0)
         $display("matrix3x3_inverse_core regression: pass");
      else
         $display("matrix3x3_inverse_core regression: fail");
      $finish;
   end

   // request driver, bursts with gaps; acceptance comes from the rising edge
   int burst_left = 0;
   int gap_left = 0;
   always @(negedge clock) begin
      matrix_type m;
      bit         hold;
      if (!reset) begin
         if (req_taken) begin
            void'(pending_matrices.pop_front());
         end
         hold = req_valid && !req_taken;
         if (!hold) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_matrices.size() > 0) begin
               m = pending_matrices[0];
               for (int i = 0; i < 9; i++) req_in[i] <= m.e[i];
               req_valid <= 1'b1;
               if (burst_left > 0) burst_left--;
               else begin
                  burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 30);
                  gap_left = $urandom_range(0, 8);
               end
            end else begin
               req_valid <= 1'b0;
               stim_done = 1'b1;
            end
         end
      end
   end

   // response stall pattern
   int stall_phase = 0;
   always @(negedge clock) begin
      stall_phase = (stall_phase + 1) % 160;
      if (stall_phase < 40) rsp_ready <= 1'b1;
      else if (stall_phase < 50) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(0, 3) != 0);
   end

   // predict on accepted request, check on accepted response
   always @(posedge clock) begin
      inverse_type exp_inv;
      matrix_type  m;
      req_taken = !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            for (int i = 0; i < 9; i++) m.e[i] = req_in[i];
            expected_inverses.push_back(invert_matrix(m));
            idle_cycles = 0;
         end
         if (rsp_valid && rsp_ready) begin
            idle_cycles = 0;
            if (expected_inverses.size() == 0) begin
               $error("response with no request outstanding");
               n_fail++;
            end else begin
               exp_inv = expected_inverses.pop_front();
               n_done++;
               if (exp_inv.singular) n_singular++;
               if (exp_inv.saturated) n_sat++;
               for (int i = 0; i < 9; i++)
                  if (rsp_out[i] !== exp_inv.inv[i]) begin
                     $error("out_%0d%0d expected %0d actual %0d", i / 3, i % 3,
                            exp_inv.inv[i], rsp_out[i]);
                     n_fail++;
                  end
               if (rsp_singular !== exp_inv.singular) begin
                  $error("singular expected %0b actual %0b", exp_inv.singular, rsp_singular);
                  n_fail++;
               end
               if (rsp_saturated !== exp_inv.saturated) begin
                  $error("saturated expected %0b actual %0b", exp_inv.saturated,
                         rsp_saturated);
                  n_fail++;
               end
            end
         end
         // watchdog
         idle_cycles++;
         if (idle_cycles > STALL_LIMIT) begin
            $display("matrix3x3_inverse_core regression: fail");
            $finish;
         end
      end
   end

endmodule

`default_nettype wire
